@@ hw/rtl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define NCL_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define NCL_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ hw/rtl/ncl_pkg.sv @@
package ncl_pkg;

  // default tally width and fixed result width
  localparam int CountBitsDef = 32;
  localparam int TotalBits    = 32;

  // characters the scanner reacts to
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChFf      = 8'h0C;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChDquote  = 8'h22;
  localparam logic [7:0] ChSquote  = 8'h27;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChPrintLo = 8'h20;
  localparam logic [7:0] ChPrintHi = 8'h7E;

  // lexical context
  typedef enum logic [6:0] {
    ModeCode  = 7'b0000001,
    ModeSlash = 7'b0000010,
    ModeLine  = 7'b0000100,
    ModeBlock = 7'b0001000,
    ModeStar  = 7'b0010000,
    ModeLit   = 7'b0100000,
    ModeEsc   = 7'b1000000
  } scan_mode_e;

  // what the current line holds so far
  typedef enum logic [2:0] {
    ClassEmpty = 3'b001,
    ClassCode  = 3'b010,
    ClassJunk  = 3'b100
  } line_class_e;

  // one byte step handed to the scanner
  typedef struct packed {
    logic       valid;
    logic       eof;
    logic [7:0] data;
  } ncl_item_t;

  // next scanner state plus a count request
  typedef struct packed {
    scan_mode_e  mode;
    line_class_e cls;
    logic        single;
    logic        cnt;
  } scan_upd_t;

  function automatic logic is_junk(logic [7:0] c);
    return !(c inside {[ChPrintLo:ChPrintHi]});
  endfunction

  // tab and form feed are ordinary inside comments and literals
  function automatic logic inner_junk(logic [7:0] c);
    return is_junk(c) && (c != ChTab) && (c != ChFf);
  endfunction

  // handling of a byte seen in code context
  function automatic scan_upd_t code_byte(line_class_e cls, logic single, logic [7:0] c);
    scan_upd_t u;
    u.mode   = ModeCode;
    u.cls    = cls;
    u.single = single;
    u.cnt    = 1'b0;
    if (!(c inside {ChSpace, ChTab, ChFf})) begin
      if (c == ChNewline) begin
        u.cnt = (cls == ClassCode);
        u.cls = ClassEmpty;
      end else if (c == ChSlash) begin
        if (cls != ClassJunk) begin
          u.mode = ModeSlash;
        end
      end else if (c inside {ChDquote, ChSquote}) begin
        if (cls != ClassJunk) begin
          u.cls    = ClassCode;
          u.single = (c == ChSquote);
          u.mode   = ModeLit;
        end
      end else if (is_junk(c)) begin
        u.cls = ClassJunk;
      end else if (cls == ClassEmpty) begin
        u.cls = ClassCode;
      end
    end
    return u;
  endfunction

endpackage

@@ hw/rtl/ncl_scan.sv @@
module ncl_scan import ncl_pkg::*; #(
  parameter int CountBits = CountBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ncl_item_t            item_i,
  output logic [CountBits-1:0] tally_o
);

  scan_mode_e           mode_q;
  line_class_e          cls_q;
  logic                 single_q;
  logic [CountBits-1:0] tally_q, tally_d;
  scan_upd_t            upd;
  logic [7:0]           c;

  assign c = item_i.data;

  // next lexical state for the byte in the input register
  always_comb begin
    upd = '{mode: mode_q, cls: cls_q, single: single_q, cnt: 1'b0};
    case (mode_q)
      ModeCode: begin
        upd = code_byte(cls_q, single_q, c);
      end
      ModeSlash: begin
        if (c == ChSlash) begin
          upd.mode = ModeLine;
        end else if (c == ChStar) begin
          upd.mode = ModeBlock;
        end else begin
          upd = code_byte((cls_q == ClassEmpty) ? ClassCode : cls_q, single_q, c);
        end
      end
      ModeLine: begin
        if (c == ChNewline) begin
          upd.cnt  = (cls_q == ClassCode);
          upd.cls  = ClassEmpty;
          upd.mode = ModeCode;
        end else if (inner_junk(c)) begin
          upd.cls  = ClassJunk;
          upd.mode = ModeCode;
        end
      end
      ModeBlock, ModeStar: begin
        if (c == ChNewline) begin
          upd.cnt  = (cls_q == ClassCode);
          upd.cls  = ClassEmpty;
          upd.mode = ModeBlock;
        end else if (c == ChStar) begin
          upd.mode = ModeStar;
        end else if (c == ChSlash && mode_q == ModeStar) begin
          upd.mode = ModeCode;
        end else if (inner_junk(c)) begin
          upd.cls  = ClassJunk;
          upd.mode = ModeCode;
        end else begin
          upd.mode = ModeBlock;
        end
      end
      ModeLit: begin
        if (c inside {ChDquote, ChSquote}) begin
          if ((c == ChSquote) == single_q) begin
            upd.mode = ModeCode;
          end
        end else if (c == ChNewline) begin
          upd.cnt  = (cls_q == ClassCode);
          upd.cls  = ClassEmpty;
          upd.mode = ModeCode;
        end else if (c == ChBslash) begin
          upd.mode = ModeEsc;
        end else if (inner_junk(c)) begin
          upd.cls  = ClassJunk;
          upd.mode = ModeCode;
        end
      end
      ModeEsc: begin
        // escaped newline continues the literal and counts a line
        if (c == ChNewline) begin
          upd.cnt  = 1'b1;
          upd.mode = ModeLit;
        end else if (inner_junk(c)) begin
          upd.cls  = ClassJunk;
          upd.mode = ModeCode;
        end else begin
          upd.mode = ModeLit;
        end
      end
      default: begin
        upd = code_byte(cls_q, single_q, c);
      end
    endcase
  end

  // saturating line tally
  assign tally_d = (upd.cnt && (tally_q != '1)) ? tally_q + 1'b1 : tally_q;

  // state registers, cleared by reset and by the end marker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeCode;
      cls_q    <= ClassEmpty;
      single_q <= 1'b0;
      tally_q  <= '0;
    end else if (item_i.valid) begin
      if (item_i.eof) begin
        mode_q   <= ModeCode;
        cls_q    <= ClassEmpty;
        single_q <= 1'b0;
        tally_q  <= '0;
      end else begin
        mode_q   <= upd.mode;
        cls_q    <= upd.cls;
        single_q <= upd.single;
        tally_q  <= tally_d;
      end
    end
  end

  assign tally_o = tally_q;

endmodule

@@ hw/rtl/noncomment_line_counter.sv @@
// Counts non-comment source lines of a C byte stream. One byte is taken per
// cycle with no gaps unless the input side is held; the scanner state is updated
// from the input register, so the next byte can follow at once. A transaction with
// end_of_file set produces one result (the saturated tally, low 32 bits) by way of
// the input register and the result register and restarts the count; it holds the input side
// only while an earlier result is still waiting at the output register.
module noncomment_line_counter import ncl_pkg::*; #(
  parameter int COUNT_BITS = CountBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           byte_in_i,
  input  logic                 end_of_file_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [TotalBits-1:0] line_total_o
);

  ncl_item_t             in_q;
  ncl_item_t             step;
  logic                  advance;
  logic                  in_fire;
  logic [COUNT_BITS-1:0] tally;
  logic [TotalBits-1:0]  total;
  logic                  out_valid_q;
  logic [TotalBits-1:0]  out_total_q;

  // input register moves on unless an end marker meets a full output
  assign advance    = in_q.valid && (!in_q.eof || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_q.valid && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (in_fire) begin
      in_q <= '{valid: 1'b1, eof: end_of_file_i, data: byte_in_i};
    end else if (advance) begin
      in_q.valid <= 1'b0;
    end
  end

  assign step = '{valid: advance, eof: in_q.eof, data: in_q.data};

  ncl_scan #(
    .CountBits(COUNT_BITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (step),
    .tally_o(tally)
  );

  // fit the tally to the result width
  if (COUNT_BITS >= TotalBits) begin : g_trunc
    assign total = tally[TotalBits-1:0];
  end else begin : g_extend
    assign total = {{(TotalBits-COUNT_BITS){1'b0}}, tally};
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_q.eof) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_q.eof) begin
      out_total_q <= total;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_total_o = out_total_q;

endmodule

@@ hw/rtl/ncl_checker.sv @@
`include "assert_macros.svh"

module ncl_checker import ncl_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic [7:0]           byte_in_i,
  input logic                 end_of_file_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [TotalBits-1:0] line_total_o
);

  logic in_fire_eof;
  assign in_fire_eof = in_valid_i && !in_stall_o && end_of_file_i;

  // a held result keeps its value
  `NCL_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(line_total_o))

  // the input side is only held back by a waiting result
  `NCL_ASSERT_NEVER(a_stall_cause, in_stall_o && !(out_valid_o && out_stall_i))

  // a fresh result comes from an end marker transaction
  `NCL_ASSERT(a_result_origin, $rose(out_valid_o) |-> $past(in_fire_eof, 2))

  // an end marker into an idle output shows up as a result
  `NCL_ASSERT(a_result_latency, in_fire_eof ##1 !out_valid_o |=> out_valid_o)

endmodule

bind noncomment_line_counter ncl_checker u_ncl_checker (.*);

@@ tb/tb.sv @@
module tb;
  import ncl_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int LongHold  = 150;
  localparam int RandItems = 525;

  // one input transaction, with an optional hand-written expected total
  typedef struct {
    logic [7:0]  data;
    logic        eof;
    logic        typed;
    logic [31:0] total;
  } src_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           byte_in_i = 8'h00;
  logic                 end_of_file_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [TotalBits-1:0] line_total_o;

  // predictor state
  scan_mode_e  lex_mode = ModeCode;
  line_class_e line_kind = ClassEmpty;
  logic        quote_single = 1'b0;
  logic [31:0] line_count = '0;

  logic [31:0] want_totals[$];
  logic [7:0]  file_text[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          fed = 0;
  logic        hold_req = 1'b0;

  // short directed file: every scan mode, extremes of the byte, end markers
  src_row_t directed [25] = '{
    '{8'hFF,     1'b1, 1'b1, 32'd0},  // end marker right after reset
    '{ChSlash,   1'b0, 1'b0, 32'd0},  // lone slash then newline counts
    '{ChNewline, 1'b0, 1'b0, 32'd0},
    '{ChSlash,   1'b0, 1'b0, 32'd0},  // block comment across a newline
    '{ChStar,    1'b0, 1'b0, 32'd0},
    '{ChNewline, 1'b0, 1'b0, 32'd0},
    '{ChStar,    1'b0, 1'b0, 32'd0},
    '{ChSlash,   1'b0, 1'b0, 32'd0},
    '{ChDquote,  1'b0, 1'b0, 32'd0},  // string with tab and escaped newline
    '{ChTab,     1'b0, 1'b0, 32'd0},
    '{ChBslash,  1'b0, 1'b0, 32'd0},
    '{ChNewline, 1'b0, 1'b0, 32'd0},
    '{ChDquote,  1'b0, 1'b0, 32'd0},
    '{ChNewline, 1'b0, 1'b0, 32'd0},
    '{8'hFF,     1'b0, 1'b0, 32'd0},  // junk line, slash dropped
    '{ChSlash,   1'b0, 1'b0, 32'd0},
    '{ChNewline, 1'b0, 1'b0, 32'd0},
    '{ChSlash,   1'b0, 1'b0, 32'd0},  // line comment with form feed
    '{ChSlash,   1'b0, 1'b0, 32'd0},
    '{ChFf,      1'b0, 1'b0, 32'd0},
    '{ChNewline, 1'b0, 1'b0, 32'd0},
    '{ChSquote,  1'b0, 1'b0, 32'd0},  // char literal hit by a zero byte
    '{8'h00,     1'b0, 1'b0, 32'd0},
    '{8'h00,     1'b1, 1'b0, 32'd0},  // unterminated last line
    '{8'h5A,     1'b1, 1'b1, 32'd0}   // second marker in a row
  };

  always #5 clk_i = ~clk_i;

  noncomment_line_counter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .byte_in_i     (byte_in_i),
    .end_of_file_i (end_of_file_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .line_total_o  (line_total_o)
  );

  function automatic logic ctrl_byte(logic [7:0] c);
    return (c < 8'h20) || (c > 8'h7E);
  endfunction

  // inside comments and literals tab and form feed are plain text
  function automatic logic ctrl_in_text(logic [7:0] c);
    return ctrl_byte(c) && (c != ChTab) && (c != ChFf);
  endfunction

  task automatic add_line();
    if (line_count != 32'hFFFF_FFFF) line_count = line_count + 32'd1;
  endtask

  task automatic close_line();
    if (line_kind == ClassCode) add_line();
    line_kind = ClassEmpty;
  endtask

  task automatic mark_junk();
    line_kind = ClassJunk;
    lex_mode  = ModeCode;
  endtask

  task automatic code_char(logic [7:0] c);
    lex_mode = ModeCode;
    if (c == ChSpace || c == ChTab || c == ChFf) begin
    end else if (c == ChNewline) begin
      close_line();
    end else if (c == ChSlash) begin
      if (line_kind != ClassJunk) lex_mode = ModeSlash;
    end else if (c == ChDquote || c == ChSquote) begin
      if (line_kind != ClassJunk) begin
        line_kind    = ClassCode;
        quote_single = (c == ChSquote);
        lex_mode     = ModeLit;
      end
    end else if (ctrl_byte(c)) begin
      line_kind = ClassJunk;
    end else if (line_kind == ClassEmpty) begin
      line_kind = ClassCode;
    end
  endtask

  // advance the scanner by one transaction, return the total on an end marker
  task automatic scan_byte(input logic [7:0] c, input logic eof,
                           output logic emits, output logic [31:0] total);
    emits = eof;
    total = line_count;
    if (eof) begin
      lex_mode     = ModeCode;
      line_kind    = ClassEmpty;
      quote_single = 1'b0;
      line_count   = '0;
    end else begin
      case (lex_mode)
        ModeSlash: begin
          if (c == ChSlash) lex_mode = ModeLine;
          else if (c == ChStar) lex_mode = ModeBlock;
          else begin
            if (line_kind == ClassEmpty) line_kind = ClassCode;
            code_char(c);
          end
        end
        ModeLine: begin
          if (c == ChNewline) begin
            close_line();
            lex_mode = ModeCode;
          end else if (ctrl_in_text(c)) mark_junk();
        end
        ModeBlock, ModeStar: begin
          if (c == ChNewline) begin
            close_line();
            lex_mode = ModeBlock;
          end else if (c == ChStar) lex_mode = ModeStar;
          else if (c == ChSlash && lex_mode == ModeStar) lex_mode = ModeCode;
          else if (ctrl_in_text(c)) mark_junk();
          else lex_mode = ModeBlock;
        end
        ModeLit: begin
          if (c == ChDquote || c == ChSquote) begin
            if ((c == ChSquote) == quote_single) lex_mode = ModeCode;
          end else if (c == ChNewline) begin
            close_line();
            lex_mode = ModeCode;
          end else if (c == ChBslash) lex_mode = ModeEsc;
          else if (ctrl_in_text(c)) mark_junk();
        end
        ModeEsc: begin
          if (c == ChNewline) begin
            add_line();
            lex_mode = ModeLit;
          end else if (ctrl_in_text(c)) mark_junk();
          else lex_mode = ModeLit;
        end
        default: code_char(c);
      endcase
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // offer one transaction, wait for it to go in, then maybe idle
  task automatic send_row(src_row_t row, bit calm);
    logic        emits;
    logic [31:0] total;
    int          g;
    in_valid_i    <= 1'b1;
    byte_in_i     <= row.data;
    end_of_file_i <= row.eof;
    do @(posedge clk_i); while (in_stall_o);
    scan_byte(row.data, row.eof, emits, total);
    if (emits) want_totals.push_back(row.typed ? row.total : total);
    g = calm ? 0 : pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) file_text.push_back(s[i]);
  endtask

  // random source file made of C-like fragments, closed by an end marker
  task automatic send_file(int len, bit calm);
    src_row_t row;
    file_text.delete();
    while (file_text.size() < len) begin
      case ($urandom_range(0, 15))
        0, 1: push_text("\n");
        2:  push_text("/*");
        3:  push_text("*/");
        4:  push_text("//");
        5:  push_text("\"");
        6:  push_text("'");
        7:  push_text("\\\n");
        8:  push_text("\\");
        9:  file_text.push_back(($urandom_range(0, 1) == 0) ? ChTab : ChFf);
        10: push_text(" ");
        11: push_text(($urandom_range(0, 1) == 0) ? "*" : "/");
        12: file_text.push_back(8'($urandom_range(8'h21, 8'h7E)));
        13: file_text.push_back(8'($urandom_range(0, 255)));
        default: push_text("x = 1;");
      endcase
    end
    foreach (file_text[i]) begin
      row = '{file_text[i], 1'b0, 1'b0, 32'd0};
      send_row(row, calm);
    end
    row = '{8'($urandom_range(0, 255)), 1'b1, 1'b0, 32'd0};
    send_row(row, calm);
    fed += file_text.size() + 1;
  endtask

  // hold the input side until every pending total has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (want_totals.size() != 0) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    int files;
    int len;
    files = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_row(directed[i], 1'b0);
    drain();
    while (fed < RandItems) begin
      if (files == 6) begin
        // receiver holds off while short files keep coming back to back
        hold_req = 1'b1;
        repeat (8) send_file($urandom_range(2, 6), 1'b1);
      end
      if (files == 30) drain();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 16);
      send_file(len, $urandom_range(0, 3) == 0);
      files++;
    end
    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // output side stalls
  initial begin
    int  n;
    int  phase_left;
    bit  calm;
    phase_left = 0;
    calm = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (phase_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(40, 200);
      end
      phase_left--;
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LongHold - 1) @(posedge clk_i);
      end else if (calm || $urandom_range(0, 99) < 65) begin
        out_stall_i <= 1'b0;
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
        out_stall_i <= 1'b1;
        repeat (n - 1) @(posedge clk_i);
      end
    end
  end

  // compare each total with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (want_totals.size() == 0) begin
        report("unexpected line_total", line_total_o, 32'd0);
      end else begin
        if (line_total_o !== want_totals[0]) begin
          report("line_total", line_total_o, want_totals[0]);
        end
        void'(want_totals.pop_front());
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IdleLimit) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

@@ noncomment_line_counter.f @@
+incdir+hw/rtl
hw/rtl/ncl_pkg.sv
hw/rtl/ncl_scan.sv
hw/rtl/noncomment_line_counter.sv
hw/rtl/ncl_checker.sv
tb/tb.sv
